@@ rtl/sbda_pkg.sv @@
// Shared constants and types for the signed binary to decimal ASCII converter.
package sbda_pkg;

  localparam int VALUE_IN_W  = 64;
  localparam int VALUE_WIDTH = 64;
  localparam int DIGIT_W     = 4;
  localparam int DIGITS      = ((VALUE_WIDTH - 1) * 1233) / 4096 + 1;
  localparam int BCD_W       = DIGITS * DIGIT_W;
  localparam int BIT_CNT_W   = $clog2(VALUE_WIDTH + 1);
  localparam int DIG_CNT_W   = $clog2(DIGITS + 1);
  localparam int CHAR_W      = 8;

  localparam logic [CHAR_W-1:0]  CHAR_ZERO   = 8'd48;
  localparam logic [CHAR_W-1:0]  CHAR_MINUS  = 8'd45;
  localparam logic [DIGIT_W-1:0] DIGIT_FIVE  = 4'd5;
  localparam logic [DIGIT_W-1:0] DIGIT_THREE = 4'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_SKIP,
    S_SIGN,
    S_EMIT
  } state_t;

endpackage

@@ rtl/signed_binary_to_decimal_ascii.sv @@
// Top level: bit-serial signed binary to decimal ASCII text converter.
//
//   channel | ports                                  | direction
//   --------+----------------------------------------+----------
//   in      | in_valid, in_stall, in_value           | request in
//   out     | out_valid, out_stall, out_character,   | request out
//           | out_last                               |
//
// The shift-add-3 loop takes one input bit per cycle; leading zero digits
// are then dropped one per cycle, and digits leave one per cycle while
// the output is not stalled.
// rst_n is synchronous, active low, and returns the block to idle.
// A stalled character holds in the output register and the sequencer waits.
module signed_binary_to_decimal_ascii
  import sbda_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [VALUE_IN_W-1:0] in_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic        [CHAR_W-1:0]     out_character,
  output logic                         out_last
);

  state_t                 state_r, state_nxt;
  logic [VALUE_WIDTH-1:0] mag_r;
  logic                   neg_r;
  logic [BCD_W-1:0]       bcd_r;
  logic [BCD_W-1:0]       bcd_adj;
  logic [BIT_CNT_W-1:0]   bit_cnt_r;
  logic [DIG_CNT_W-1:0]   dig_cnt_r;
  logic                   out_valid_r;
  logic [CHAR_W-1:0]      out_char_r;
  logic                   out_last_r;

  logic [VALUE_WIDTH-1:0] raw;
  logic [VALUE_WIDTH-1:0] mag_in;
  logic [DIGIT_W-1:0]     top_digit;
  logic                   last_digit;
  logic                   slot_free;
  logic                   accept;
  logic                   out_load;
  logic [CHAR_W-1:0]      out_char_nxt;
  logic                   out_last_nxt;
  logic                   skip_shift;
  logic                   emit_shift;

  assign raw        = in_value[VALUE_WIDTH-1:0];
  assign mag_in     = raw[VALUE_WIDTH-1] ? (~raw + 1'b1) : raw;
  assign top_digit  = bcd_r[BCD_W-1 -: DIGIT_W];
  assign last_digit = (dig_cnt_r == DIG_CNT_W'(1));
  assign slot_free  = !out_valid_r || !out_stall;
  assign accept     = in_valid && !in_stall;

  always_comb begin
    logic [DIGIT_W-1:0] d;
    d = '0;
    for (int i = 0; i < DIGITS; i++) begin
      d = bcd_r[i*DIGIT_W +: DIGIT_W];
      bcd_adj[i*DIGIT_W +: DIGIT_W] = (d >= DIGIT_FIVE) ? d + DIGIT_THREE : d;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_CONV;
      S_CONV: if (bit_cnt_r == BIT_CNT_W'(1)) state_nxt = S_SKIP;
      S_SKIP: begin
        if (top_digit != '0 || last_digit) state_nxt = neg_r ? S_SIGN : S_EMIT;
      end
      S_SIGN: if (slot_free) state_nxt = S_EMIT;
      S_EMIT: if (slot_free && last_digit) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall     = (state_r != S_IDLE) || !rst_n;
    out_load     = (state_r == S_SIGN || state_r == S_EMIT) && slot_free;
    out_char_nxt = (state_r == S_SIGN) ? CHAR_MINUS
                                       : CHAR_ZERO + CHAR_W'(top_digit);
    out_last_nxt = (state_r == S_EMIT) && last_digit;
    skip_shift   = (state_r == S_SKIP) && top_digit == '0 && !last_digit;
    emit_shift   = (state_r == S_EMIT) && slot_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      neg_r       <= 1'b0;
      bit_cnt_r   <= '0;
      dig_cnt_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_load || (out_valid_r && out_stall);
      if (accept) begin
        neg_r     <= raw[VALUE_WIDTH-1];
        bit_cnt_r <= BIT_CNT_W'(VALUE_WIDTH);
        dig_cnt_r <= DIG_CNT_W'(DIGITS);
      end else if (state_r == S_CONV) begin
        bit_cnt_r <= bit_cnt_r - 1'b1;
      end else if (skip_shift || emit_shift) begin
        dig_cnt_r <= dig_cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mag_r <= mag_in;
      bcd_r <= '0;
    end else if (state_r == S_CONV) begin
      mag_r <= mag_r << 1;
      bcd_r <= {bcd_adj[BCD_W-2:0], mag_r[VALUE_WIDTH-1]};
    end else if (skip_shift || emit_shift) begin
      bcd_r <= bcd_r << DIGIT_W;
    end
    if (out_load) begin
      out_char_r <= out_char_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

  a_accept_starts_conv: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_CONV)
    else $error("accepted request did not start conversion");

  a_conv_ends_in_skip: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CONV && bit_cnt_r == BIT_CNT_W'(1)) |=> state_r == S_SKIP)
    else $error("conversion did not end after the last bit");

  a_emit_has_digits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT || state_r == S_SIGN) |-> dig_cnt_r != '0)
    else $error("emitting with no digits left");

  a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_char_r == CHAR_MINUS ||
                     (out_char_r >= CHAR_ZERO && out_char_r <= CHAR_ZERO + 8'd9)))
    else $error("output character is neither a digit nor a minus sign");

endmodule

@@ dv/signed_binary_to_decimal_ascii_tb.sv @@
// Self-checking testbench for the signed binary to decimal ASCII converter.
`timescale 1ns / 1ps

module signed_binary_to_decimal_ascii_tb
  import sbda_pkg::*;
();

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } ascii_char_t;

  typedef struct {
    logic signed [VALUE_IN_W-1:0] value;
    string                        text;
  } vector_t;

  localparam int DIRECTED_COUNT = 19;
  localparam int RANDOM_COUNT   = 300;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic signed [VALUE_IN_W-1:0] in_value = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic        [CHAR_W-1:0]     out_character;
  logic                         out_last;

  ascii_char_t text_q[$];
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          fail_count = 0;
  int          mismatch_count = 0;

  vector_t directed_vectors [DIRECTED_COUNT] = '{
    '{64'sd0, "0"},
    '{64'sd1, "1"},
    '{-64'sd1, "-1"},
    '{64'sd9, "9"},
    '{64'sd10, "10"},
    '{-64'sd10, "-10"},
    '{64'sd100, "100"},
    '{64'sd12345, "12345"},
    '{-64'sd98765, "-98765"},
    '{64'sh7FFF_FFFF_FFFF_FFFF, "9223372036854775807"},
    '{64'sh8000_0000_0000_0000, "-9223372036854775808"},
    '{64'sh8000_0000_0000_0001, "-9223372036854775807"},
    '{64'sd999999999999999999, "999999999999999999"},
    '{64'sd1000000000000000000, "1000000000000000000"},
    '{-64'sd1000000000000000000, "-1000000000000000000"},
    '{64'sh0000_0000_FFFF_FFFF, "4294967295"},
    '{64'sh5555_5555_5555_5555, ""},
    '{64'shAAAA_AAAA_AAAA_AAAA, ""},
    '{64'shFFFF_FFFF_0000_0000, ""}
  };

  signed_binary_to_decimal_ascii dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_character (out_character),
    .out_last      (out_last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void push_decimal_text(logic signed [VALUE_IN_W-1:0] v);
    logic [VALUE_WIDTH-1:0] raw;
    logic [VALUE_WIDTH-1:0] mag;
    logic                   negative;
    logic [CHAR_W-1:0]      digits[$];
    ascii_char_t            c;
    raw = v[VALUE_WIDTH-1:0];
    negative = raw[VALUE_WIDTH-1];
    mag = negative ? (~raw + 1'b1) : raw;
    do begin
      digits.push_front(CHAR_ZERO + CHAR_W'(mag % 10));
      mag = mag / 10;
    end while (mag != 0);
    if (negative) begin
      c.character = CHAR_MINUS;
      c.last = 1'b0;
      text_q.push_back(c);
    end
    foreach (digits[i]) begin
      c.character = digits[i];
      c.last = (i == digits.size() - 1);
      text_q.push_back(c);
    end
  endfunction

  function automatic void push_typed_text(string text);
    ascii_char_t c;
    for (int i = 0; i < text.len(); i++) begin
      c.character = text[i];
      c.last = (i == text.len() - 1);
      text_q.push_back(c);
    end
  endfunction

  function automatic logic signed [VALUE_IN_W-1:0] random_value();
    logic signed [VALUE_IN_W-1:0] v;
    logic        [VALUE_IN_W-1:0] pow10;
    case ($urandom_range(3))
      0: v = {$urandom, $urandom};
      1: v = {$urandom, $urandom} >> $urandom_range(63);
      2: begin
        pow10 = 1;
        repeat ($urandom_range(18)) pow10 = pow10 * 10;
        v = pow10 + $urandom_range(2) - 1;
      end
      default: v = $urandom_range(999);
    endcase
    if ($urandom_range(1)) v = -v;
    return v;
  endfunction

  task automatic send_request(logic signed [VALUE_IN_W-1:0] v, string text);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      in_value <= {$urandom, $urandom};
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (in_stall);
    if (text.len() != 0) push_typed_text(text);
    else push_decimal_text(v);
  endtask

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    ascii_char_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (text_q.size() == 0) begin
        fail_count++;
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected output: char %0d last %0d", out_character, out_last);
      end else begin
        want = text_q.pop_front();
        if (out_character !== want.character || out_last !== want.last) begin
          fail_count++;
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected char %0d last %0d, got char %0d last %0d",
                     want.character, want.last, out_character, out_last);
        end
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 28;
    recv_stall_pct = 63;
    foreach (directed_vectors[i])
      send_request(directed_vectors[i].value, directed_vectors[i].text);

    for (int i = 0; i < RANDOM_COUNT; i++) begin
      if (i == RANDOM_COUNT / 3) begin
        send_idle_pct = 63;
        recv_stall_pct = 28;
      end else if (i == 2 * RANDOM_COUNT / 3) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      send_request(random_value(), "");
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (text_q.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
